@@ rtl/core/lcq_pkg.sv @@
// Package for the lock and condition queue manager.
// Opcode and status codes, default sizes, controller state, command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package lcq_pkg;

  localparam int NUM_LOCKS_DEF   = 8;
  localparam int NUM_CONDS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TASK_BITS_DEF   = 8;

  // fixed field widths of the request and result beats
  localparam int OP_W     = 3;
  localparam int LIDX_W   = 3;
  localparam int CIDX_W   = 3;
  localparam int TASKF_W  = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOCK_INIT,
    OP_LOCK,
    OP_TRYLOCK,
    OP_UNLOCK,
    OP_COND_INIT,
    OP_COND_WAIT,
    OP_SIGNAL,
    OP_NOP
  } opcode_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_POP,
    S_CENT,
    S_LMETA
  } ctrl_state_t;

  typedef struct packed {
    logic take;      // capture request, read lock and condition state
    logic fin_meta;  // finish a request that needs only the state words
    logic rd_pop;    // read the head of the lock's wait queue
    logic fin_pop;   // hand the lock to that waiter
    logic rd_cent;   // read the head of the condition queue
    logic rd_wmeta;  // read the state of the waiter's lock
    logic fin_cent;  // finish a signal whose waiter names no lock
    logic fin_sig;   // apply the lock rule to the woken waiter
  } lcq_cmd_t;

  typedef struct packed {
    logic want_pop;
    logic want_cent;
    logic wl_ok;
    logic res_free;
  } lcq_stat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                granted;
    logic                queued;
    logic                task_valid;
    logic [TASKF_W-1:0]  task_out;
    logic [LIDX_W-1:0]   lock_out;
  } lcq_res_t;

endpackage

@@ rtl/core/lcq_req_if.sv @@
// Request channel of the lock and condition queue manager.
// Depends on lcq_pkg for field widths.
`timescale 1ns / 1ps

interface lcq_req_if;
  import lcq_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [LIDX_W-1:0]  lock_index;
  logic [CIDX_W-1:0]  cond_index;
  logic [TASKF_W-1:0] task_id;

  modport source (output valid, opcode, lock_index, cond_index, task_id, input ready);
  modport sink   (input valid, opcode, lock_index, cond_index, task_id, output ready);
endinterface

@@ rtl/core/lcq_res_if.sv @@
// Result channel of the lock and condition queue manager.
// Depends on lcq_pkg for field widths.
`timescale 1ns / 1ps

interface lcq_res_if;
  import lcq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                granted;
  logic                queued;
  logic                task_valid;
  logic [TASKF_W-1:0]  task_out;
  logic [LIDX_W-1:0]   lock_out;

  modport source (output valid, status, granted, queued, task_valid, task_out, lock_out,
                  input ready);
  modport sink   (input valid, status, granted, queued, task_valid, task_out, lock_out,
                  output ready);
endinterface

@@ rtl/core/lcq_ctrl.sv @@
// Sequencer of the lock and condition queue manager.
// Steps each request through the state reads it needs; uses lcq_pkg.
`timescale 1ns / 1ps

module lcq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcq_pkg::lcq_stat_t stat,
  output lcq_pkg::lcq_cmd_t  cmd
);
  import lcq_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_META;
      S_META: begin
        if (stat.want_pop)       state_next = S_POP;
        else if (stat.want_cent) state_next = S_CENT;
        else if (stat.res_free)  state_next = S_IDLE;
      end
      S_POP:   if (stat.res_free) state_next = S_IDLE;
      S_CENT: begin
        if (stat.wl_ok)         state_next = S_LMETA;
        else if (stat.res_free) state_next = S_IDLE;
      end
      S_LMETA: if (stat.res_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        // take no beat while reset is held
        in_ready = !rst;
        cmd.take = in_valid && !rst;
      end
      S_META: begin
        if (stat.want_pop)       cmd.rd_pop   = 1'b1;
        else if (stat.want_cent) cmd.rd_cent  = 1'b1;
        else                     cmd.fin_meta = stat.res_free;
      end
      S_POP:   cmd.fin_pop = stat.res_free;
      S_CENT: begin
        if (stat.wl_ok) cmd.rd_wmeta = 1'b1;
        else            cmd.fin_cent = stat.res_free;
      end
      S_LMETA: cmd.fin_sig = stat.res_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/lcq_dpath.sv @@
// Datapath of the lock and condition queue manager: per-lock and per-condition
// state, the two wait-queue memories and the result register. Uses lcq_pkg.
`timescale 1ns / 1ps

module lcq_dpath #(
  parameter int NUM_LOCKS   = lcq_pkg::NUM_LOCKS_DEF,
  parameter int NUM_CONDS   = lcq_pkg::NUM_CONDS_DEF,
  parameter int QUEUE_DEPTH = lcq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = lcq_pkg::TASK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lcq_pkg::lcq_cmd_t           cmd,
  output lcq_pkg::lcq_stat_t          stat,
  input  logic [lcq_pkg::OP_W-1:0]    opcode,
  input  logic [lcq_pkg::LIDX_W-1:0]  lock_index,
  input  logic [lcq_pkg::CIDX_W-1:0]  cond_index,
  input  logic [lcq_pkg::TASKF_W-1:0] task_id,
  lcq_res_if.source                   rsp
);
  import lcq_pkg::*;

  localparam int LW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int NW  = (NUM_CONDS > 1) ? $clog2(NUM_CONDS) : 1;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = TASK_BITS;
  localparam int LSD = NUM_LOCKS * QUEUE_DEPTH;
  localparam int CSD = NUM_CONDS * QUEUE_DEPTH;
  localparam int LAW = $clog2(LSD);
  localparam int CAW = $clog2(CSD);
  localparam int EW  = TW + LIDX_W;

  // request
  opcode_t            r_op;
  logic [LIDX_W-1:0]  r_l;
  logic [LIDX_W-1:0]  cur_l;
  logic [CIDX_W-1:0]  r_c;
  logic [TW-1:0]      r_task;

  // per-lock state; the owner id is never visible at the ports, so only held is kept
  logic           lm_held [NUM_LOCKS];
  logic [QW-1:0]  lm_head [NUM_LOCKS];
  logic [CW-1:0]  lm_cnt  [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] lm_vld;
  logic           rd_lvld, rd_lheld;
  logic [QW-1:0]  rd_lhead;
  logic [CW-1:0]  rd_lcnt;

  // per-condition state
  logic [QW-1:0]  cm_head [NUM_CONDS];
  logic [CW-1:0]  cm_cnt  [NUM_CONDS];
  logic [NUM_CONDS-1:0] cm_vld;
  logic           rd_cvld;
  logic [QW-1:0]  rd_chead;
  logic [CW-1:0]  rd_ccnt;

  // wait queues
  logic [TW-1:0]  ls_mem [LSD];
  logic [EW-1:0]  cs_mem [CSD];
  logic [TW-1:0]  rd_ls;
  logic [EW-1:0]  rd_cent;

  // write controls
  logic           lm_we, lm_clr, lm_wheld;
  logic [QW-1:0]  lm_whead;
  logic [CW-1:0]  lm_wcnt;
  logic           ls_we;
  logic [TW-1:0]  ls_wdata;
  logic           cm_we, cm_clr;
  logic [QW-1:0]  cm_whead;
  logic [CW-1:0]  cm_wcnt;
  logic           cs_we;

  lcq_res_t       res;

  // effective state words: an entry never written reads as reset
  logic           lheld;
  logic [QW-1:0]  lhd, chd, lhd_inc, chd_inc, lslot, cslot;
  logic [CW-1:0]  lct, cct;
  logic [CW:0]    lsum, csum;
  logic           l_full, c_full, l_ok, c_ok;
  logic [LW-1:0]  lidx, lidx_in, lidx_wl;
  logic [NW-1:0]  cidx, cidx_in;
  logic [LAW-1:0] ls_addr;
  logic [CAW-1:0] cs_addr;
  logic [LIDX_W-1:0] wl;
  logic [TW-1:0]  wt;

  assign lheld = rd_lvld & rd_lheld;
  assign lhd   = rd_lvld ? rd_lhead : '0;
  assign lct   = rd_lvld ? rd_lcnt  : '0;
  assign chd   = rd_cvld ? rd_chead : '0;
  assign cct   = rd_cvld ? rd_ccnt  : '0;

  assign lsum  = (CW+1)'(lhd) + (CW+1)'(lct);
  assign csum  = (CW+1)'(chd) + (CW+1)'(cct);
  assign lslot = (lsum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(lsum - (CW+1)'(QUEUE_DEPTH)) : QW'(lsum);
  assign cslot = (csum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(csum - (CW+1)'(QUEUE_DEPTH)) : QW'(csum);
  assign lhd_inc = (lhd == QW'(QUEUE_DEPTH - 1)) ? '0 : lhd + QW'(1);
  assign chd_inc = (chd == QW'(QUEUE_DEPTH - 1)) ? '0 : chd + QW'(1);
  assign l_full  = (lct == CW'(QUEUE_DEPTH));
  assign c_full  = (cct == CW'(QUEUE_DEPTH));

  assign l_ok = (32'(r_l) < NUM_LOCKS);
  assign c_ok = (32'(r_c) < NUM_CONDS);

  assign wl = rd_cent[EW-1:TW];
  assign wt = rd_cent[TW-1:0];

  assign lidx    = LW'(cur_l);
  assign lidx_in = LW'(lock_index);
  assign lidx_wl = LW'(wl);
  assign cidx    = NW'(r_c);
  assign cidx_in = NW'(cond_index);

  assign ls_addr = LAW'(lidx) * LAW'(QUEUE_DEPTH) + LAW'(cmd.rd_pop ? lhd : lslot);
  assign cs_addr = CAW'(cidx) * CAW'(QUEUE_DEPTH) + CAW'(cmd.rd_cent ? chd : cslot);

  assign stat.want_pop  = (r_op == OP_UNLOCK) && l_ok && (lct != '0);
  assign stat.want_cent = (r_op == OP_SIGNAL) && c_ok && (cct != '0);
  assign stat.wl_ok     = (32'(wl) < NUM_LOCKS);
  assign stat.res_free  = !rsp.valid || rsp.ready;

  // request capture and lock address
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      r_op   <= opcode_t'(opcode);
      r_l    <= lock_index;
      cur_l  <= lock_index;
      r_c    <= cond_index;
      r_task <= TW'(task_id);
    end else if (cmd.rd_wmeta) begin
      cur_l  <= wl;
    end
  end

  // lock state: registered read, valid bit per lock
  always_ff @(posedge clk) begin
    if (cmd.take || cmd.rd_wmeta) begin
      rd_lvld  <= lm_vld[cmd.take ? lidx_in : lidx_wl];
      rd_lheld <= lm_held[cmd.take ? lidx_in : lidx_wl];
      rd_lhead <= lm_head[cmd.take ? lidx_in : lidx_wl];
      rd_lcnt  <= lm_cnt[cmd.take ? lidx_in : lidx_wl];
    end
    if (lm_we) begin
      lm_held[lidx] <= lm_wheld;
      lm_head[lidx] <= lm_whead;
      lm_cnt[lidx]  <= lm_wcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lm_vld <= '0;
    end else if (lm_clr) begin
      lm_vld[lidx] <= 1'b0;
    end else if (lm_we) begin
      lm_vld[lidx] <= 1'b1;
    end
  end

  // condition state
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_cvld  <= cm_vld[cidx_in];
      rd_chead <= cm_head[cidx_in];
      rd_ccnt  <= cm_cnt[cidx_in];
    end
    if (cm_we) begin
      cm_head[cidx] <= cm_whead;
      cm_cnt[cidx]  <= cm_wcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cm_vld <= '0;
    end else if (cm_clr) begin
      cm_vld[cidx] <= 1'b0;
    end else if (cm_we) begin
      cm_vld[cidx] <= 1'b1;
    end
  end

  // wait-queue memories
  always_ff @(posedge clk) begin
    if (cmd.rd_pop) rd_ls <= ls_mem[ls_addr];
    if (ls_we)      ls_mem[ls_addr] <= ls_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cent) rd_cent <= cs_mem[cs_addr];
    if (cs_we)       cs_mem[cs_addr] <= {r_l, r_task};
  end

  always_comb begin
    res      = '0;
    lm_we    = 1'b0;
    lm_clr   = 1'b0;
    lm_wheld = 1'b1;
    lm_whead = lhd;
    lm_wcnt  = lct;
    ls_we    = 1'b0;
    ls_wdata = cmd.fin_sig ? wt : r_task;
    cm_we    = 1'b0;
    cm_clr   = 1'b0;
    cm_whead = chd;
    cm_wcnt  = cct;
    cs_we    = 1'b0;

    if (cmd.fin_meta) begin
      if (r_op inside {OP_LOCK_INIT, OP_LOCK, OP_TRYLOCK, OP_UNLOCK, OP_COND_WAIT}) begin
        res.lock_out = r_l;
      end
      case (r_op)
        OP_LOCK_INIT: lm_clr = l_ok;
        OP_LOCK: begin
          if (l_ok) begin
            if (!lheld) begin
              lm_we       = 1'b1;
              res.granted = 1'b1;
            end else if (l_full) begin
              res.status = ST_FULL;
            end else begin
              ls_we      = 1'b1;
              lm_we      = 1'b1;
              lm_wcnt    = lct + CW'(1);
              res.queued = 1'b1;
            end
          end
        end
        OP_TRYLOCK: begin
          if (l_ok) begin
            if (!lheld) begin
              lm_we       = 1'b1;
              res.granted = 1'b1;
            end else begin
              res.status = ST_BUSY;
            end
          end
        end
        OP_UNLOCK: begin
          // no waiters here: free the lock, queue pointers stay
          if (l_ok) begin
            lm_we    = 1'b1;
            lm_wheld = 1'b0;
          end
        end
        OP_COND_INIT: cm_clr = c_ok;
        OP_COND_WAIT: begin
          if (c_ok && l_ok) begin
            if (c_full) begin
              res.status = ST_FULL;
            end else begin
              cs_we      = 1'b1;
              cm_we      = 1'b1;
              cm_wcnt    = cct + CW'(1);
              res.queued = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.fin_pop) begin
      lm_we          = 1'b1;
      lm_whead       = lhd_inc;
      lm_wcnt        = lct - CW'(1);
      res.granted    = 1'b1;
      res.task_valid = 1'b1;
      res.task_out   = TASKF_W'(rd_ls);
      res.lock_out   = r_l;
    end

    if (cmd.fin_cent) res.lock_out = wl;

    if (cmd.fin_sig) begin
      res.lock_out = wl;
      if (lheld && l_full) begin
        // waiter stays at the head of the condition queue
        res.status = ST_FULL;
      end else begin
        lm_we          = 1'b1;
        cm_we          = 1'b1;
        cm_whead       = chd_inc;
        cm_wcnt        = cct - CW'(1);
        res.task_valid = 1'b1;
        res.task_out   = TASKF_W'(wt);
        if (!lheld) begin
          res.granted = 1'b1;
        end else begin
          ls_we      = 1'b1;
          lm_wcnt    = lct + CW'(1);
          res.queued = 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.fin_meta || cmd.fin_pop || cmd.fin_cent || cmd.fin_sig) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_meta || cmd.fin_pop || cmd.fin_cent || cmd.fin_sig) begin
      rsp.status     <= res.status;
      rsp.granted    <= res.granted;
      rsp.queued     <= res.queued;
      rsp.task_valid <= res.task_valid;
      rsp.task_out   <= res.task_out;
      rsp.lock_out   <= res.lock_out;
    end
  end

endmodule

@@ rtl/core/lock_and_condition_queue_manager_unit.sv @@
// Top level of the lock and condition queue manager.
// Joins lcq_ctrl and lcq_dpath; uses lcq_pkg, lcq_req_if and lcq_res_if.
//
//   channel  role  beat carries
//   req      sink  opcode, lock_index, cond_index, task_id
//   rsp      src   status, granted, queued, task_valid, task_out, lock_out
//
// Requests pass S_IDLE and S_META; unlock with waiters adds S_POP, signal with a
// waiter S_CENT and S_LMETA. Each step is one registered read of a single-port
// state or queue memory. Reset is synchronous; per-lock and per-condition valid
// bits clear at once, so there is no clearing pass. A result stalled on rsp
// holds the next request at its last step; req is taken while a result waits.
`timescale 1ns / 1ps

module lock_and_condition_queue_manager_unit #(
  parameter int NUM_LOCKS   = lcq_pkg::NUM_LOCKS_DEF,
  parameter int NUM_CONDS   = lcq_pkg::NUM_CONDS_DEF,
  parameter int QUEUE_DEPTH = lcq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = lcq_pkg::TASK_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  lcq_req_if.sink   req,
  lcq_res_if.source rsp
);
  import lcq_pkg::*;

  lcq_cmd_t  cmd;
  lcq_stat_t stat;
  logic      in_ready;

  assign req.ready = in_ready;

  lcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcq_dpath #(
    .NUM_LOCKS   (NUM_LOCKS),
    .NUM_CONDS   (NUM_CONDS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (req.opcode),
    .lock_index (req.lock_index),
    .cond_index (req.cond_index),
    .task_id    (req.task_id),
    .rsp        (rsp)
  );

endmodule

@@ dv/lcq_grant_tracker.sv @@
// Watches the request and result channels of the lock and condition queue manager,
// keeps its own copy of lock and condition state and checks every result beat.
// Depends on lcq_pkg, lcq_req_if and lcq_res_if.
`timescale 1ns / 1ps

module lcq_grant_tracker #(
  parameter int NUM_LOCKS   = lcq_pkg::NUM_LOCKS_DEF,
  parameter int NUM_CONDS   = lcq_pkg::NUM_CONDS_DEF,
  parameter int QUEUE_DEPTH = lcq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = lcq_pkg::TASK_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  lcq_req_if    req,
  lcq_res_if    rsp,
  output int    fault_count,
  output int    outstanding,
  output int    n_grant,
  output int    n_queued,
  output int    n_busy,
  output int    n_full
);
  import lcq_pkg::*;

  localparam logic [TASKF_W-1:0] TASK_MASK = TASKF_W'((1 << TASK_BITS) - 1);

  typedef enum logic [1:0] {
    RULE_GRANT,
    RULE_QUEUED,
    RULE_FULL
  } lock_rule_t;

  logic [TASKF_W-1:0] owner      [NUM_LOCKS];
  logic               held       [NUM_LOCKS];
  logic [TASKF_W-1:0] lock_waiter[NUM_LOCKS][QUEUE_DEPTH];
  int                 lock_head  [NUM_LOCKS];
  int                 lock_count [NUM_LOCKS];
  logic [TASKF_W-1:0] cond_task  [NUM_CONDS][QUEUE_DEPTH];
  logic [LIDX_W-1:0]  cond_lock  [NUM_CONDS][QUEUE_DEPTH];
  int                 cond_head  [NUM_CONDS];
  int                 cond_count [NUM_CONDS];

  lcq_res_t pending_outcomes[$];
  lcq_res_t want;
  lcq_res_t seen;
  int       mismatches;
  int       result_no;

  // grant a free lock, else append the task to its wait queue
  function automatic lock_rule_t apply_lock_rule(int l, logic [TASKF_W-1:0] t);
    int slot;
    if (!held[l]) begin
      held[l]  = 1'b1;
      owner[l] = t;
      return RULE_GRANT;
    end
    if (lock_count[l] >= QUEUE_DEPTH) return RULE_FULL;
    slot = (lock_head[l] + lock_count[l]) % QUEUE_DEPTH;
    lock_waiter[l][slot] = t;
    lock_count[l]++;
    return RULE_QUEUED;
  endfunction

  function automatic lcq_res_t arbitrate_request(opcode_t op, logic [LIDX_W-1:0] l,
                                                 logic [CIDX_W-1:0] c,
                                                 logic [TASKF_W-1:0] tid);
    lcq_res_t           r;
    logic [TASKF_W-1:0] t;
    logic [TASKF_W-1:0] wt;
    logic [LIDX_W-1:0]  wl;
    lock_rule_t         rule;
    int                 slot;
    r = '0;
    t = tid & TASK_MASK;
    if (op <= OP_UNLOCK || op == OP_COND_WAIT) r.lock_out = l;
    if (op <= OP_UNLOCK && int'(l) < NUM_LOCKS) begin
      case (op)
        OP_LOCK_INIT: begin
          owner[l]      = '0;
          held[l]       = 1'b0;
          lock_head[l]  = 0;
          lock_count[l] = 0;
        end
        OP_LOCK: begin
          rule = apply_lock_rule(l, t);
          if (rule == RULE_GRANT) r.granted = 1'b1;
          else if (rule == RULE_QUEUED) r.queued = 1'b1;
          else r.status = ST_FULL;
        end
        OP_TRYLOCK: begin
          if (!held[l]) begin
            held[l]   = 1'b1;
            owner[l]  = t;
            r.granted = 1'b1;
          end else begin
            r.status = ST_BUSY;
          end
        end
        default: begin
          // unlock: pass to the oldest waiter, or free the lock
          if (lock_count[l] > 0) begin
            owner[l]     = lock_waiter[l][lock_head[l]];
            lock_head[l] = (lock_head[l] + 1) % QUEUE_DEPTH;
            lock_count[l]--;
            r.granted    = 1'b1;
            r.task_valid = 1'b1;
            r.task_out   = owner[l];
          end else begin
            held[l]  = 1'b0;
            owner[l] = '0;
          end
        end
      endcase
    end else if (op >= OP_COND_INIT && op <= OP_SIGNAL && int'(c) < NUM_CONDS) begin
      case (op)
        OP_COND_INIT: begin
          cond_head[c]  = 0;
          cond_count[c] = 0;
        end
        OP_COND_WAIT: begin
          if (int'(l) < NUM_LOCKS) begin
            if (cond_count[c] >= QUEUE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              slot = (cond_head[c] + cond_count[c]) % QUEUE_DEPTH;
              cond_task[c][slot] = t;
              cond_lock[c][slot] = l;
              cond_count[c]++;
              r.queued = 1'b1;
            end
          end
        end
        default: begin
          if (cond_count[c] > 0) begin
            wt = cond_task[c][cond_head[c]] & TASK_MASK;
            wl = cond_lock[c][cond_head[c]];
            r.lock_out = wl;
            if (int'(wl) < NUM_LOCKS) begin
              rule = apply_lock_rule(wl, wt);
              // hold the pair at the head when the lock queue is full
              if (rule == RULE_FULL) begin
                r.status = ST_FULL;
              end else begin
                cond_head[c] = (cond_head[c] + 1) % QUEUE_DEPTH;
                cond_count[c]--;
                r.task_valid = 1'b1;
                r.task_out   = wt;
                if (rule == RULE_GRANT) r.granted = 1'b1;
                else r.queued = 1'b1;
              end
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
        owner[i]      = '0;
        held[i]       = 1'b0;
        lock_head[i]  = 0;
        lock_count[i] = 0;
      end
      for (int i = 0; i < NUM_CONDS; i++) begin
        cond_head[i]  = 0;
        cond_count[i] = 0;
      end
      pending_outcomes.delete();
      fault_count = 0;
      mismatches  = 0;
      result_no   = 0;
      n_grant     = 0;
      n_queued    = 0;
      n_busy      = 0;
      n_full      = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen = '{status: rsp.status, granted: rsp.granted, queued: rsp.queued,
                 task_valid: rsp.task_valid, task_out: rsp.task_out,
                 lock_out: rsp.lock_out};
        if (pending_outcomes.size() == 0) begin
          fault_count++;
          if (mismatches < 10)
            $display("result beat %0d arrived with no request outstanding", result_no);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (seen.status != want.status || seen.granted != want.granted ||
              seen.queued != want.queued || seen.task_valid != want.task_valid ||
              seen.task_out != want.task_out || seen.lock_out != want.lock_out) begin
            fault_count++;
            if (mismatches < 10) begin
              $display("result %0d expected st=%0d gr=%0b q=%0b tv=%0b task=%02h lock=%0d",
                       result_no, want.status, want.granted, want.queued,
                       want.task_valid, want.task_out, want.lock_out);
              $display("result %0d actual   st=%0d gr=%0b q=%0b tv=%0b task=%02h lock=%0d",
                       result_no, seen.status, seen.granted, seen.queued,
                       seen.task_valid, seen.task_out, seen.lock_out);
            end
            mismatches++;
          end
          if (want.granted) n_grant++;
          if (want.queued) n_queued++;
          if (want.status == ST_BUSY) n_busy++;
          if (want.status == ST_FULL) n_full++;
        end
        result_no++;
      end
      if (req.valid && req.ready)
        pending_outcomes.push_back(arbitrate_request(opcode_t'(req.opcode), req.lock_index,
                                                     req.cond_index, req.task_id));
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

@@ dv/tb_lock_and_condition_queue_manager_unit.sv @@
// Top of the lock and condition queue manager bench: clock, reset, request stimulus
// and result back-pressure; lcq_grant_tracker does the checking beside the block.
// Depends on lcq_pkg, lcq_req_if, lcq_res_if and the block itself.
`timescale 1ns / 1ps

module tb_lock_and_condition_queue_manager_unit;
  import lcq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 193;

  logic clk = 1'b0;
  logic rst;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   cycles = 0;
  int   sent = 0;
  int   faults, outstanding, n_grant, n_queued, n_busy, n_full;

  lcq_req_if req_ch ();
  lcq_res_if rsp_ch ();

  lock_and_condition_queue_manager_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lcq_grant_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fault_count (faults),
    .outstanding (outstanding),
    .n_grant     (n_grant),
    .n_queued    (n_queued),
    .n_busy      (n_busy),
    .n_full      (n_full)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_lock_and_condition_queue_manager_unit: errors");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high into the next beat
  task automatic send_req(input opcode_t op, input logic [LIDX_W-1:0] l,
                          input logic [CIDX_W-1:0] c, input logic [TASKF_W-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.lock_index <= l;
    req_ch.cond_index <= c;
    req_ch.task_id    <= t;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    opcode_t            op;
    logic [LIDX_W-1:0]  l;
    logic [LIDX_W-1:0]  focus_lock;
    logic [CIDX_W-1:0]  c;
    logic [CIDX_W-1:0]  focus_cond;
    logic [TASKF_W-1:0] t;
    int                 mode, seg, p, budget;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = '0;
    req_ch.lock_index = '0;
    req_ch.cond_index = '0;
    req_ch.task_id    = '0;
    rsp_ch.ready      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 28;
    recv_idle = 61;

    // grant, relock by owner, busy trylock, hand-over and release
    send_req(OP_LOCK_INIT, 3'd0, 3'd0, 8'h00);
    send_req(OP_LOCK,      3'd0, 3'd0, 8'h00);
    send_req(OP_LOCK,      3'd0, 3'd0, 8'h00);
    send_req(OP_TRYLOCK,   3'd0, 3'd7, 8'hFF);
    send_req(OP_TRYLOCK,   3'd7, 3'd7, 8'hFF);
    send_req(OP_LOCK,      3'd0, 3'd0, 8'hA5);
    send_req(OP_UNLOCK,    3'd0, 3'd0, 8'h00);
    send_req(OP_UNLOCK,    3'd0, 3'd0, 8'h00);
    send_req(OP_UNLOCK,    3'd0, 3'd0, 8'h00);
    send_req(OP_UNLOCK,    3'd0, 3'd0, 8'h00);
    // empty signal, wake onto a held lock and onto a free one
    send_req(OP_COND_INIT, 3'd0, 3'd7, 8'h00);
    send_req(OP_SIGNAL,    3'd0, 3'd7, 8'h00);
    send_req(OP_COND_WAIT, 3'd7, 3'd7, 8'h5A);
    send_req(OP_COND_WAIT, 3'd3, 3'd7, 8'h81);
    send_req(OP_SIGNAL,    3'd0, 3'd7, 8'h00);
    send_req(OP_SIGNAL,    3'd0, 3'd7, 8'h00);
    send_req(OP_UNLOCK,    3'd7, 3'd0, 8'h00);
    send_req(OP_LOCK_INIT, 3'd7, 3'd0, 8'h00);
    // clearing a condition drops its waiters
    send_req(OP_COND_WAIT, 3'd1, 3'd0, 8'h01);
    send_req(OP_COND_INIT, 3'd0, 3'd0, 8'h00);
    send_req(OP_SIGNAL,    3'd0, 3'd0, 8'h00);
    send_req(OP_NOP,       3'd5, 3'd2, 8'h3C);
    send_req(OP_LOCK_INIT, 3'd3, 3'd0, 8'h00);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 28; recv_idle = 61; end
        1: begin send_idle = 61; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      budget = PHASE_ITEMS;
      while (budget > 0) begin
        p          = $urandom_range(9);
        mode       = (p < 2) ? 0 : (p < 7) ? 1 : 2;
        seg        = (mode == 2) ? 40 : 30;
        focus_lock = LIDX_W'($urandom_range(7));
        focus_cond = CIDX_W'($urandom_range(7));
        for (int k = 0; k < seg && budget > 0; k++) begin
          l = LIDX_W'($urandom_range(7));
          c = CIDX_W'($urandom_range(7));
          t = TASKF_W'($urandom_range(255));
          p = $urandom_range(99);
          case (mode)
            0: op = opcode_t'($urandom_range(7));
            1: begin
              if (p < 30) op = OP_LOCK;
              else if (p < 40) op = OP_TRYLOCK;
              else if (p < 70) op = OP_UNLOCK;
              else if (p < 82) op = OP_COND_WAIT;
              else if (p < 96) op = OP_SIGNAL;
              else if (p < 98) op = OP_LOCK_INIT;
              else op = OP_COND_INIT;
            end
            default: begin
              // hammer one lock and one condition so that both queues fill
              l = focus_lock;
              c = focus_cond;
              if (p < 45) op = OP_LOCK;
              else if (p < 70) op = OP_COND_WAIT;
              else if (p < 85) op = OP_SIGNAL;
              else if (p < 95) op = OP_UNLOCK;
              else op = OP_TRYLOCK;
            end
          endcase
          send_req(op, l, c, t);
          budget--;
        end
      end
    end
    req_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d requests over three back-pressure phases", sent);
    $display("results seen: %0d grants, %0d queued, %0d busy, %0d queue full",
             n_grant, n_queued, n_busy, n_full);
    if (faults == 0) begin
      $display("tb_lock_and_condition_queue_manager_unit: clean");
    end else begin
      $display("tb_lock_and_condition_queue_manager_unit: errors");
    end
    $finish;
  end

endmodule

@@ lock_and_condition_queue_manager_unit.f @@
rtl/core/lcq_pkg.sv
rtl/core/lcq_req_if.sv
rtl/core/lcq_res_if.sv
rtl/core/lcq_ctrl.sv
rtl/core/lcq_dpath.sv
rtl/core/lock_and_condition_queue_manager_unit.sv
dv/lcq_grant_tracker.sv
dv/tb_lock_and_condition_queue_manager_unit.sv
